>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed");

// Check that a condition at one edge implies another at the next edge.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> hw/rtl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg
// Types, constants and the pattern table of the line follower steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfps_pkg;

  localparam int NUM_SENSORS = 7;
  localparam int CFG_DATA_W  = 56;
  localparam int CFG_IDX_W   = 3;
  localparam int SUM_W       = 15;

  localparam logic [8:0] LINE_MARGIN = 9'd20;
  localparam logic [7:0] DUTY_MAX    = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_FAST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIVOT_SLOW   = 3'd5;

  // sensor patterns
  localparam logic [6:0] PAT_ALL      = 7'h7F;
  localparam logic [6:0] PAT_R4       = 7'h06;
  localparam logic [6:0] PAT_R3       = 7'h04;
  localparam logic [6:0] PAT_R2       = 7'h0C;
  localparam logic [6:0] PAT_C1       = 7'h08;
  localparam logic [6:0] PAT_C1_WIDE  = 7'h1C;
  localparam logic [6:0] PAT_L2       = 7'h18;
  localparam logic [6:0] PAT_L3       = 7'h10;
  localparam logic [6:0] PAT_L4       = 7'h30;
  localparam logic [6:0] PAT_NONE     = 7'h00;
  localparam logic [6:0] PAT_EDGE_R0  = 7'h01;
  localparam logic [6:0] PAT_EDGE_R1  = 7'h02;
  localparam logic [6:0] PAT_EDGE_R2  = 7'h03;
  localparam logic [6:0] PAT_EDGE_L0  = 7'h20;
  localparam logic [6:0] PAT_EDGE_L1  = 7'h40;
  localparam logic [6:0] PAT_EDGE_L2  = 7'h60;

  typedef struct packed {
    logic [7:0] prop_gain;
    logic [7:0] deriv_gain;
    logic [7:0] base_speed;
    logic [7:0] pivot_fast;
    logic [7:0] pivot_slow;
  } lfps_drive_cfg_t;

  typedef struct packed {
    logic              hit;
    logic signed [3:0] code;
    logic              set_side;
    logic              right;
    logic              ind;
  } lfps_class_t;

  typedef struct packed {
    logic [6:0]        pattern;
    logic signed [3:0] code;
    logic              on_right;
    logic              ind;
    logic signed [3:0] err;
    logic signed [4:0] diff;
  } lfps_item_t;

  typedef struct packed {
    logic [7:0]        left_duty;
    logic [7:0]        right_duty;
    logic              left_reverse;
    logic              right_reverse;
    logic [6:0]        pattern;
    logic signed [3:0] code;
    logic              ind;
  } lfps_result_t;

  function automatic lfps_class_t lfps_lookup(input logic [6:0] pat);
    lfps_class_t c;
    c = '{hit: 1'b1, code: 4'sd0, set_side: 1'b0, right: 1'b0, ind: 1'b0};
    case (pat)
      PAT_R4:      begin c.code = 4'sd4;  c.set_side = 1'b1; c.right = 1'b1; end
      PAT_R3:      begin c.code = 4'sd3;  c.set_side = 1'b1; c.right = 1'b1; end
      PAT_R2:      begin c.code = 4'sd2;  c.set_side = 1'b1; c.right = 1'b1; end
      PAT_C1:      c.code = 4'sd1;
      PAT_C1_WIDE: c.code = 4'sd1;
      PAT_L2:      begin c.code = -4'sd2; c.set_side = 1'b1; end
      PAT_L3:      begin c.code = -4'sd3; c.set_side = 1'b1; end
      PAT_L4:      begin c.code = -4'sd4; c.set_side = 1'b1; end
      PAT_ALL:     begin c.code = 4'sd4;  c.ind = 1'b1; end
      default: begin
        if (!(pat inside {PAT_NONE, PAT_EDGE_R0, PAT_EDGE_R1, PAT_EDGE_R2,
                          PAT_EDGE_L0, PAT_EDGE_L1, PAT_EDGE_L2})) begin
          c.hit = 1'b0;
        end
      end
    endcase
    return c;
  endfunction

  function automatic logic [7:0] lfps_sat(input logic signed [SUM_W-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > $signed({{(SUM_W-8){1'b0}}, DUTY_MAX})) begin
      r = DUTY_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/line_follower_pd_steering_top.sv
// ----------------------------------------------------------------------------
// line_follower_pd_steering_top
// Line follower steering: sensor thresholding, position code and PD drive.
// ----------------------------------------------------------------------------
// One scan of seven sensor samples goes in per push and one drive result comes
// out per pop, in order. A scan is taken every cycle while full is low; its
// result is written to the item queue at the edge that takes it, then to the
// output register that drives the result ports once that register is empty or
// being popped. The front keeps the position state, so consecutive scans never
// wait on each other; the back holds up to QUEUE_DEPTH classified scans plus one
// finished result while pop is low.
// Write the configuration registers only while no result is pending.
`default_nettype none

module line_follower_pd_steering_top
  import lfps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            sample_0,
  input  wire logic [7:0]            sample_1,
  input  wire logic [7:0]            sample_2,
  input  wire logic [7:0]            sample_3,
  input  wire logic [7:0]            sample_4,
  input  wire logic [7:0]            sample_5,
  input  wire logic [7:0]            sample_6,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [7:0]                 left_duty,
  output logic [7:0]                 right_duty,
  output logic                       left_reverse,
  output logic                       right_reverse,
  output logic [6:0]                 sensor_pattern,
  output logic signed [3:0]          error_code,
  output logic                       indicator
);

  logic [CFG_DATA_W-1:0] white_levels;
  lfps_drive_cfg_t       drive_cfg;
  logic [7:0]            samples [NUM_SENSORS];
  logic                  accept;
  lfps_item_t            front_item, q_item;
  logic                  q_valid, q_pop, out_valid;
  lfps_result_t          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      white_levels <= '0;
      drive_cfg    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WHITE_LEVELS: white_levels          <= cfg_data;
        REG_PROP_GAIN:    drive_cfg.prop_gain   <= cfg_data[7:0];
        REG_DERIV_GAIN:   drive_cfg.deriv_gain  <= cfg_data[7:0];
        REG_BASE_SPEED:   drive_cfg.base_speed  <= cfg_data[7:0];
        REG_PIVOT_FAST:   drive_cfg.pivot_fast  <= cfg_data[7:0];
        REG_PIVOT_SLOW:   drive_cfg.pivot_slow  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign samples[0] = sample_0;
  assign samples[1] = sample_1;
  assign samples[2] = sample_2;
  assign samples[3] = sample_3;
  assign samples[4] = sample_4;
  assign samples[5] = sample_5;
  assign samples[6] = sample_6;

  assign accept = push && !full;

  lfps_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .samples      (samples),
    .white_levels (white_levels),
    .item         (front_item)
  );

  lfps_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept),
    .wr_item (front_item),
    .full    (full),
    .rd_en   (q_pop),
    .rd_item (q_item),
    .valid   (q_valid)
  );

  lfps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .cfg       (drive_cfg),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

  assign empty          = !out_valid;
  assign left_duty      = result.left_duty;
  assign right_duty     = result.right_duty;
  assign left_reverse   = result.left_reverse;
  assign right_reverse  = result.right_reverse;
  assign sensor_pattern = result.pattern;
  assign error_code     = result.code;
  assign indicator      = result.ind;

endmodule

`default_nettype wire

>>> hw/rtl/lfps_front.sv
// ----------------------------------------------------------------------------
// lfps_front
// Thresholds a scan, classifies the pattern and tracks the position state.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_front
  import lfps_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic [7:0]            samples [NUM_SENSORS],
  input  wire logic [CFG_DATA_W-1:0] white_levels,
  output lfps_item_t                 item
);

  logic [6:0]        pattern;
  lfps_class_t       cls;
  logic signed [3:0] held_code, held_code_next;
  logic signed [3:0] previous_error;
  logic              line_on_right, line_on_right_next;
  logic              indicator_lit, indicator_lit_next;
  logic signed [3:0] err;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      pattern[i] = {1'b0, samples[i]} <= ({1'b0, white_levels[8*i +: 8]} + LINE_MARGIN);
    end
  end

  assign cls                = lfps_lookup(pattern);
  assign held_code_next     = cls.hit ? cls.code : held_code;
  assign indicator_lit_next = cls.hit ? cls.ind : indicator_lit;
  assign line_on_right_next = cls.set_side ? cls.right : line_on_right;
  assign err                = -held_code_next;

  always_comb begin
    item.pattern  = pattern;
    item.code     = held_code_next;
    item.on_right = line_on_right_next;
    item.ind      = indicator_lit_next;
    item.err      = err;
    item.diff     = 5'(err) - 5'(previous_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_code      <= '0;
      previous_error <= '0;
      line_on_right  <= 1'b0;
      indicator_lit  <= 1'b0;
    end else if (accept) begin
      held_code      <= held_code_next;
      previous_error <= err;
      line_on_right  <= line_on_right_next;
      indicator_lit  <= indicator_lit_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfps_queue.sv
// ----------------------------------------------------------------------------
// lfps_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_queue
  import lfps_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire lfps_item_t wr_item,
  output logic      full,
  input  wire logic rd_en,
  output lfps_item_t rd_item,
  output logic      valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lfps_item_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == FULL_CNT);
  assign valid   = (count != '0);
  assign rd_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfps_back.sv
// ----------------------------------------------------------------------------
// lfps_back
// Applies the PD law or the pivot rule and holds the result for transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lfps_back
  import lfps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      q_valid,
  input  wire lfps_item_t q_item,
  output logic           q_pop,
  input  wire lfps_drive_cfg_t cfg,
  input  wire logic      pop,
  output logic           out_valid,
  output lfps_result_t   result
);

  logic signed [12:0]      p_term;
  logic signed [13:0]      d_term;
  logic signed [SUM_W-1:0] base_s, u1, u2;
  lfps_result_t            res_next;

  assign q_pop = q_valid && (!out_valid || pop);

  assign p_term = 13'($signed({1'b0, cfg.prop_gain})) * 13'(q_item.err);
  assign d_term = 14'($signed({1'b0, cfg.deriv_gain})) * 14'(q_item.diff);
  assign base_s = $signed({{(SUM_W-8){1'b0}}, cfg.base_speed});
  assign u1     = base_s + SUM_W'(p_term) + SUM_W'(d_term);
  assign u2     = base_s - SUM_W'(p_term) - SUM_W'(d_term);

  always_comb begin
    res_next.pattern = q_item.pattern;
    res_next.code    = q_item.code;
    res_next.ind     = q_item.ind;
    if (q_item.code == 4'sd0) begin
      if (q_item.on_right) begin
        res_next.left_duty     = cfg.pivot_fast;
        res_next.left_reverse  = 1'b0;
        res_next.right_duty    = cfg.pivot_slow;
        res_next.right_reverse = 1'b1;
      end else begin
        res_next.left_duty     = cfg.pivot_slow;
        res_next.left_reverse  = 1'b1;
        res_next.right_duty    = cfg.pivot_fast;
        res_next.right_reverse = 1'b0;
      end
    end else begin
      res_next.left_duty     = lfps_sat(u2);
      res_next.left_reverse  = 1'b0;
      res_next.right_duty    = lfps_sat(u1);
      res_next.right_reverse = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lfps_checker.sv
// ----------------------------------------------------------------------------
// lfps_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lfps_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [7:0]        left_duty,
  input wire logic [7:0]        right_duty,
  input wire logic              left_reverse,
  input wire logic              right_reverse,
  input wire logic signed [3:0] error_code,
  input wire logic              indicator
);

  logic reversing;

  assign reversing = left_reverse || right_reverse;

  `CHK_ALWAYS(a_one_wheel_reversed, clk, rst, empty || !(left_reverse && right_reverse))

  `CHK_ALWAYS(a_reverse_only_pivot, clk, rst, empty || !reversing || error_code == 4'sd0)

  `CHK_ALWAYS(a_indicator_code, clk, rst, empty || !indicator || error_code == 4'sd4)

  `CHK_NEXT(a_stall_holds, clk, rst, !empty && !pop, !empty && $stable({left_duty, right_duty}))

endmodule

bind line_follower_pd_steering_top lfps_checker u_lfps_checker (
  .clk           (clk),
  .rst           (rst),
  .empty         (empty),
  .pop           (pop),
  .left_duty     (left_duty),
  .right_duty    (right_duty),
  .left_reverse  (left_reverse),
  .right_reverse (right_reverse),
  .error_code    (error_code),
  .indicator     (indicator)
);

`default_nettype wire

>>> tb/sv/line_follower_pd_steering_top_tb.sv
// ----------------------------------------------------------------------------
// line_follower_pd_steering_top_tb
// Drives sensor scans through the line follower steering block and checks
// every drive result against a PD steering predictor held in a scoreboard,
// across directed scans, extreme and random register settings, and random
// push and pop idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_follower_pd_steering_top_tb
  import lfps_pkg::*;
();

  localparam int CYCLE_LIMIT = 200000;
  localparam int MARGIN      = 20;
  localparam int DUTY_TOP    = 255;

  typedef enum int {SIDE_KEEP, SIDE_LEFT, SIDE_RIGHT} side_t;

  class steering_scoreboard;
    logic [CFG_DATA_W-1:0] white;
    int prop, deriv, base, fast, slow;
    int held_code;
    int prev_err;
    bit on_right;
    bit ind_lit;
    int fails;
    lfps_result_t expected_drive[$];

    function new();
      white = '0;
      prop = 0;
      deriv = 0;
      base = 0;
      fast = 0;
      slow = 0;
      held_code = 0;
      prev_err = 0;
      on_right = 0;
      ind_lit = 0;
      fails = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WHITE_LEVELS: white = data;
        REG_PROP_GAIN:    prop = int'(data[7:0]);
        REG_DERIV_GAIN:   deriv = int'(data[7:0]);
        REG_BASE_SPEED:   base = int'(data[7:0]);
        REG_PIVOT_FAST:   fast = int'(data[7:0]);
        REG_PIVOT_SLOW:   slow = int'(data[7:0]);
        default: ;
      endcase
    endfunction

    function logic [7:0] clamp_duty(int v);
      if (v < 0) return 8'd0;
      if (v > DUTY_TOP) return 8'(DUTY_TOP);
      return 8'(v);
    endfunction

    function void note_scan(logic [CFG_DATA_W-1:0] s);
      logic [6:0] pat;
      int code;
      side_t side;
      bit hit;
      int err, d, u1, u2;
      lfps_result_t r;
      pat = '0;
      for (int i = 0; i < NUM_SENSORS; i++) begin
        if (int'(s[8*i +: 8]) <= int'(white[8*i +: 8]) + MARGIN) pat[i] = 1'b1;
      end
      hit = 1;
      code = 0;
      side = SIDE_KEEP;
      case (pat)
        PAT_R4:      begin code = 4;  side = SIDE_RIGHT; end
        PAT_R3:      begin code = 3;  side = SIDE_RIGHT; end
        PAT_R2:      begin code = 2;  side = SIDE_RIGHT; end
        PAT_C1:      code = 1;
        PAT_C1_WIDE: code = 1;
        PAT_L2:      begin code = -2; side = SIDE_LEFT; end
        PAT_L3:      begin code = -3; side = SIDE_LEFT; end
        PAT_L4:      begin code = -4; side = SIDE_LEFT; end
        PAT_ALL:     code = 4;
        PAT_NONE, PAT_EDGE_R0, PAT_EDGE_R1, PAT_EDGE_R2,
        PAT_EDGE_L0, PAT_EDGE_L1, PAT_EDGE_L2: code = 0;
        default:     hit = 0;
      endcase
      if (hit) begin
        held_code = code;
        ind_lit = (pat == PAT_ALL);
        if (side != SIDE_KEEP) on_right = (side == SIDE_RIGHT);
      end
      err = -held_code;
      d = err - prev_err;
      u1 = base + prop * err + deriv * d;
      u2 = base - prop * err - deriv * d;
      prev_err = err;
      r.pattern = pat;
      r.code = 4'(held_code);
      r.ind = ind_lit;
      if (held_code == 0) begin
        if (on_right) begin
          r.left_duty = 8'(fast);
          r.left_reverse = 1'b0;
          r.right_duty = 8'(slow);
          r.right_reverse = 1'b1;
        end else begin
          r.left_duty = 8'(slow);
          r.left_reverse = 1'b1;
          r.right_duty = 8'(fast);
          r.right_reverse = 1'b0;
        end
      end else begin
        r.left_duty = clamp_duty(u2);
        r.right_duty = clamp_duty(u1);
        r.left_reverse = 1'b0;
        r.right_reverse = 1'b0;
      end
      expected_drive.push_back(r);
    endfunction

    function void compare_field(string name, int e, int a);
      if (e != a) begin
        $error("%s expected %0d actual %0d", name, e, a);
        fails++;
      end
    endfunction

    function void check_drive(lfps_result_t got);
      lfps_result_t e;
      if (expected_drive.size() == 0) begin
        $error("drive result with nothing expected");
        fails++;
        return;
      end
      e = expected_drive.pop_front();
      compare_field("left_duty", int'(e.left_duty), int'(got.left_duty));
      compare_field("right_duty", int'(e.right_duty), int'(got.right_duty));
      compare_field("left_reverse", int'(e.left_reverse), int'(got.left_reverse));
      compare_field("right_reverse", int'(e.right_reverse), int'(got.right_reverse));
      compare_field("sensor_pattern", int'(e.pattern), int'(got.pattern));
      compare_field("error_code", int'($signed(e.code)), int'($signed(got.code)));
      compare_field("indicator", int'(e.ind), int'(got.ind));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic [CFG_DATA_W-1:0] scan = '0;
  logic                  full, empty;
  logic [7:0]            left_duty, right_duty;
  logic                  left_reverse, right_reverse;
  logic [6:0]            sensor_pattern;
  logic signed [3:0]     error_code;
  logic                  indicator;

  steering_scoreboard sb;
  int send_idle = 25;
  int recv_idle = 61;
  int cycles = 0;

  line_follower_pd_steering_top uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .sample_0(scan[7:0]),
    .sample_1(scan[15:8]),
    .sample_2(scan[23:16]),
    .sample_3(scan[31:24]),
    .sample_4(scan[39:32]),
    .sample_5(scan[47:40]),
    .sample_6(scan[55:48]),
    .empty(empty),
    .pop(pop),
    .left_duty(left_duty),
    .right_duty(right_duty),
    .left_reverse(left_reverse),
    .right_reverse(right_reverse),
    .sensor_pattern(sensor_pattern),
    .error_code(error_code),
    .indicator(indicator)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL line_follower_pd_steering_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      sb.check_drive('{left_duty, right_duty, left_reverse, right_reverse,
                       sensor_pattern, error_code, indicator});
    end
    pop <= !rst && ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [CFG_DATA_W-1:0] make_scan(logic [6:0] pat,
                                                      logic [CFG_DATA_W-1:0] wl);
    logic [CFG_DATA_W-1:0] s;
    int w, hi, v;
    s = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      w = int'(wl[8*i +: 8]);
      hi = (w + MARGIN > DUTY_TOP) ? DUTY_TOP : w + MARGIN;
      if (pat[i]) v = $urandom_range(hi, 0);
      else if (w + MARGIN + 1 <= DUTY_TOP) v = $urandom_range(DUTY_TOP, w + MARGIN + 1);
      else v = DUTY_TOP;
      s[8*i +: 8] = 8'(v);
    end
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_white(int hi);
    logic [CFG_DATA_W-1:0] wl;
    for (int i = 0; i < NUM_SENSORS; i++) wl[8*i +: 8] = 8'($urandom_range(hi, 0));
    return wl;
  endfunction

  function automatic logic [6:0] listed_pattern(int k);
    case (k)
      0:  return PAT_NONE;
      1:  return PAT_R4;
      2:  return PAT_R3;
      3:  return PAT_R2;
      4:  return PAT_C1;
      5:  return PAT_C1_WIDE;
      6:  return PAT_L2;
      7:  return PAT_L3;
      8:  return PAT_L4;
      9:  return PAT_EDGE_R0;
      10: return PAT_EDGE_R1;
      11: return PAT_EDGE_R2;
      12: return PAT_EDGE_L0;
      13: return PAT_EDGE_L1;
      14: return PAT_EDGE_L2;
      15: return PAT_R3;
      16: return PAT_NONE;
      17: return 7'h55;
      18: return PAT_ALL;
      19: return 7'h2A;
      default: return PAT_C1;
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_scan();
    int r;
    r = $urandom_range(99);
    if (r < 10) return CFG_DATA_W'({$urandom, $urandom});
    if (r < 25) return make_scan(7'($urandom), sb.white);
    return make_scan(listed_pattern($urandom_range(18)), sb.white);
  endfunction

  task automatic send_scan(logic [CFG_DATA_W-1:0] s);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    scan <= s;
    do @(posedge clk); while (full);
    sb.note_scan(s);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.expected_drive.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] wl,
                           logic [7:0] pg, dg, bs, pf, ps);
    logic [CFG_DATA_W-1:0] vals [6];
    logic [CFG_IDX_W-1:0]  idx [6];
    vals[0] = wl;
    vals[1] = CFG_DATA_W'(pg);
    vals[2] = CFG_DATA_W'(dg);
    vals[3] = CFG_DATA_W'(bs);
    vals[4] = CFG_DATA_W'(pf);
    vals[5] = CFG_DATA_W'(ps);
    idx[0] = REG_WHITE_LEVELS;
    idx[1] = REG_PROP_GAIN;
    idx[2] = REG_DERIV_GAIN;
    idx[3] = REG_BASE_SPEED;
    idx[4] = REG_PIVOT_FAST;
    idx[5] = REG_PIVOT_SLOW;
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(idx[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic run_items(int n, int pause_at);
    for (int k = 0; k < n; k++) begin
      if (k == pause_at) drain();
      send_scan(random_scan());
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    configure({7{8'd80}}, 8'd30, 8'd10, 8'd128, 8'd200, 8'd60);
    for (int k = 0; k < 21; k++) send_scan(make_scan(listed_pattern(k), sb.white));
    send_scan('0);
    send_scan('1);
    drain();

    configure({7{8'hFF}}, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    send_scan('1);
    send_scan('0);
    drain();

    configure(random_white(200), 8'd255, 8'd255, 8'd255, 8'd255, 8'd0);
    run_items(160, 80);
    drain();

    send_idle = 61;
    recv_idle = 25;
    configure('0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    run_items(160, -1);
    drain();

    send_idle = 0;
    recv_idle = 0;
    configure(random_white(255), 8'($urandom_range(40)), 8'($urandom_range(40)),
              8'($urandom), 8'($urandom), 8'($urandom));
    run_items(170, -1);
    drain();
    repeat (8) @(posedge clk);

    if (sb.fails == 0) begin
      $display("PASS line_follower_pd_steering_top");
    end else begin
      $display("FAIL line_follower_pd_steering_top");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/lfps_pkg.sv
hw/rtl/lfps_front.sv
hw/rtl/lfps_queue.sv
hw/rtl/lfps_back.sv
hw/rtl/line_follower_pd_steering_top.sv
hw/rtl/lfps_checker.sv
tb/sv/line_follower_pd_steering_top_tb.sv
